// ===== hdl/ftdg_pkg.sv =====
// Shared types, constants and helper functions of the frame time distance governor.
// No dependencies; used by ftdg_cfg, ftdg_step and frame_time_distance_governor_top.
package ftdg_pkg;

  // Band ratios for the GPU time, clamped to their legal ranges.
  localparam int LOW_RATIO_PERMILLE  = 800;
  localparam int HIGH_RATIO_PERMILLE = 1000;
  localparam int GpuLowInt  = (LOW_RATIO_PERMILLE < 50) ? 50 :
                              (LOW_RATIO_PERMILLE > 950) ? 950 : LOW_RATIO_PERMILLE;
  localparam int GpuHighInt = (HIGH_RATIO_PERMILLE < GpuLowInt + 10) ? GpuLowInt + 10 :
                              (HIGH_RATIO_PERMILLE > 1500) ? 1500 : HIGH_RATIO_PERMILLE;

  localparam logic [10:0] GPU_LOW_R  = 11'(GpuLowInt);
  localparam logic [10:0] GPU_HIGH_R = 11'(GpuHighInt);
  localparam logic [10:0] CPU_LOW_R  = 11'd850;
  localparam logic [10:0] CPU_HIGH_R = 11'd1050;

  // floor(t * r / 1000) == (t * ceil(r * 2^30 / 1000)) >> 30 for t up to 2^20
  localparam int RecipShift = 30;
  localparam logic [30:0] GPU_LOW_MUL  =
    31'((64'(GpuLowInt) * (64'd1 << RecipShift) + 64'd999) / 64'd1000);
  localparam logic [30:0] GPU_HIGH_MUL =
    31'((64'(GpuHighInt) * (64'd1 << RecipShift) + 64'd999) / 64'd1000);
  localparam logic [30:0] CPU_LOW_MUL  =
    31'((64'd850 * (64'd1 << RecipShift) + 64'd999) / 64'd1000);
  localparam logic [30:0] CPU_HIGH_MUL =
    31'((64'd1050 * (64'd1 << RecipShift) + 64'd999) / 64'd1000);

  localparam logic [23:0] FRAME_MAX  = 24'd9999999;
  localparam logic [23:0] DT_MAX     = 24'd1000000;
  localparam logic [19:0] TARGET_MAX = 20'd1000000;
  localparam logic [15:0] DIST_RESET = 16'hFFFF;

  // Register reset values
  localparam logic        RST_ENABLE   = 1'b1;
  localparam logic [19:0] RST_TARGET   = 20'd16667;
  localparam logic [15:0] RST_MIN      = 16'd0;
  localparam logic [15:0] RST_MAX      = 16'hFFFF;
  localparam logic [15:0] RST_INIT     = 16'hFFFF;
  localparam logic [31:0] RST_STEPS    = 32'h0010_0010;
  localparam logic [47:0] RST_DELAYS   = 48'd0;
  localparam logic [23:0] RST_COOLDOWN = 24'd0;

  typedef enum logic [2:0] {
    REG_ENABLE   = 3'd0,
    REG_TARGET   = 3'd1,
    REG_MIN      = 3'd2,
    REG_MAX      = 3'd3,
    REG_INIT     = 3'd4,
    REG_STEPS    = 3'd5,
    REG_DELAYS   = 3'd6,
    REG_COOLDOWN = 3'd7
  } reg_idx_e;

  typedef enum logic [2:0] {
    DCS_DISABLED  = 3'd0,
    DCS_WAITING   = 3'd1,
    DCS_HOLDING   = 3'd2,
    DCS_INCREASED = 3'd3,
    DCS_DECREASED = 3'd4
  } decision_e;

  typedef struct packed {
    logic        enable;
    logic [19:0] target;
    logic [15:0] min_dist;
    logic [15:0] max_dist;
    logic [15:0] init_dist;
    logic [15:0] inc_step;
    logic [15:0] dec_step;
    logic [23:0] inc_delay;
    logic [23:0] dec_delay;
    logic [23:0] cooldown;
  } cfg_t;

  typedef struct packed {
    logic [15:0] distance;
    logic [24:0] headroom;
    logic [24:0] overload;
    logic [23:0] cooldown;
  } state_t;

  typedef struct packed {
    logic        rendering;
    logic        gpu_valid;
    logic [23:0] gpu_frame_us;
    logic [23:0] cpu_frame_us;
    logic [23:0] elapsed_us;
  } item_t;

  typedef struct packed {
    logic        changed;
    decision_e   decision;
    logic [15:0] distance;
    logic        used_gpu_time;
    logic        time_available;
    logic [23:0] chosen_frame_us;
    logic [20:0] low_threshold_us;
    logic [20:0] high_threshold_us;
  } result_t;

  // Upper distance bound, raised to the lower bound if below it
  function automatic logic [15:0] lim_max(input cfg_t cfg);
    return (cfg.max_dist < cfg.min_dist) ? cfg.min_dist : cfg.max_dist;
  endfunction

  function automatic logic [15:0] clamp_init(input cfg_t cfg);
    logic [15:0] mx;
    mx = lim_max(cfg);
    if (cfg.init_dist < cfg.min_dist) begin
      return cfg.min_dist;
    end else if (cfg.init_dist > mx) begin
      return mx;
    end else begin
      return cfg.init_dist;
    end
  endfunction

endpackage

// ===== hdl/ftdg_cfg.sv =====
// Configuration register file of the governor, written over an APB-style port.
// Depends on ftdg_pkg; emits the decoded settings and a one-cycle reload strobe.
module ftdg_cfg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [5:0]          paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready,
  output ftdg_pkg::cfg_t      cfg_o,
  output logic                reload_o
);

  logic        enable_q;
  logic [19:0] target_q;
  logic [15:0] min_q;
  logic [15:0] max_q;
  logic [15:0] init_q;
  logic [31:0] steps_q;
  logic [47:0] delays_q;
  logic [23:0] cooldown_q;
  logic        reload_q;
  logic        wr_en;
  ftdg_pkg::reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = ftdg_pkg::reg_idx_e'(paddr[5:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q   <= ftdg_pkg::RST_ENABLE;
      target_q   <= ftdg_pkg::RST_TARGET;
      min_q      <= ftdg_pkg::RST_MIN;
      max_q      <= ftdg_pkg::RST_MAX;
      init_q     <= ftdg_pkg::RST_INIT;
      steps_q    <= ftdg_pkg::RST_STEPS;
      delays_q   <= ftdg_pkg::RST_DELAYS;
      cooldown_q <= ftdg_pkg::RST_COOLDOWN;
      reload_q   <= 1'b0;
    end else begin
      // Any write reloads the distance in the following cycle, from the updated registers
      reload_q <= wr_en;
      if (wr_en) begin
        case (idx)
          ftdg_pkg::REG_ENABLE:   enable_q   <= pwdata[0];
          ftdg_pkg::REG_TARGET:   target_q   <= pwdata[19:0];
          ftdg_pkg::REG_MIN:      min_q      <= pwdata[15:0];
          ftdg_pkg::REG_MAX:      max_q      <= pwdata[15:0];
          ftdg_pkg::REG_INIT:     init_q     <= pwdata[15:0];
          ftdg_pkg::REG_STEPS:    steps_q    <= pwdata[31:0];
          ftdg_pkg::REG_DELAYS:   delays_q   <= pwdata[47:0];
          ftdg_pkg::REG_COOLDOWN: cooldown_q <= pwdata[23:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    case (idx)
      ftdg_pkg::REG_ENABLE:   prdata = 64'(enable_q);
      ftdg_pkg::REG_TARGET:   prdata = 64'(target_q);
      ftdg_pkg::REG_MIN:      prdata = 64'(min_q);
      ftdg_pkg::REG_MAX:      prdata = 64'(max_q);
      ftdg_pkg::REG_INIT:     prdata = 64'(init_q);
      ftdg_pkg::REG_STEPS:    prdata = 64'(steps_q);
      ftdg_pkg::REG_DELAYS:   prdata = 64'(delays_q);
      ftdg_pkg::REG_COOLDOWN: prdata = 64'(cooldown_q);
      default:                prdata = 64'd0;
    endcase
  end

  always_comb begin
    cfg_o.enable    = enable_q;
    cfg_o.target    = target_q;
    cfg_o.min_dist  = min_q;
    cfg_o.max_dist  = max_q;
    cfg_o.init_dist = init_q;
    cfg_o.inc_step  = steps_q[15:0];
    cfg_o.dec_step  = steps_q[31:16];
    cfg_o.inc_delay = delays_q[23:0];
    cfg_o.dec_delay = delays_q[47:24];
    cfg_o.cooldown  = cooldown_q;
  end

  assign reload_o = reload_q;

endmodule

// ===== hdl/ftdg_step.sv =====
// Single-pass decision logic: one frame report and the current state in,
// next state and result out. Purely combinational; depends on ftdg_pkg.
module ftdg_step (
  input  ftdg_pkg::cfg_t    cfg_i,
  input  ftdg_pkg::state_t  st_i,
  input  ftdg_pkg::item_t   item_i,
  output ftdg_pkg::state_t  st_o,
  output ftdg_pkg::result_t res_o
);

  function automatic logic [24:0] sat_add(input logic [24:0] a, input logic [19:0] b);
    logic [25:0] s;
    s = {1'b0, a} + 26'(b);
    return s[25] ? 25'h1FF_FFFF : s[24:0];
  endfunction

  logic [19:0] dt_c;
  logic [23:0] cd_dec;
  logic        gpu_ok;
  logic        cpu_ok;
  logic [23:0] frame;
  logic [19:0] target_c;
  logic [30:0] lo_x_gpu, hi_x_gpu, lo_x_cpu, hi_x_cpu;
  logic [50:0] lo_q_gpu, hi_q_gpu, lo_q_cpu, hi_q_cpu;
  logic [30:0] lo_x, hi_x;
  logic [33:0] fx;
  logic        over, under;
  logic [24:0] ov_acc, hr_acc;
  logic [15:0] mn, mx;
  logic [15:0] cur;
  logic [15:0] dec_next;
  logic [16:0] inc_sum;
  logic [15:0] inc_next;

  assign dt_c   = (item_i.elapsed_us > ftdg_pkg::DT_MAX) ?
                  ftdg_pkg::DT_MAX[19:0] : item_i.elapsed_us[19:0];
  assign cd_dec = (st_i.cooldown > 24'(dt_c)) ? st_i.cooldown - 24'(dt_c) : 24'd0;

  assign gpu_ok = item_i.gpu_valid && (item_i.gpu_frame_us != 24'd0) &&
                  (item_i.gpu_frame_us <= ftdg_pkg::FRAME_MAX);
  assign cpu_ok = (item_i.cpu_frame_us != 24'd0) &&
                  (item_i.cpu_frame_us <= ftdg_pkg::FRAME_MAX);
  assign frame  = gpu_ok ? item_i.gpu_frame_us : (cpu_ok ? item_i.cpu_frame_us : 24'd0);

  assign target_c = (cfg_i.target == 20'd0) ? 20'd1 :
                    (cfg_i.target > ftdg_pkg::TARGET_MAX) ? ftdg_pkg::TARGET_MAX :
                    cfg_i.target;

  // Exact band products for the frame compare
  assign lo_x_gpu = 31'(target_c) * 31'(ftdg_pkg::GPU_LOW_R);
  assign hi_x_gpu = 31'(target_c) * 31'(ftdg_pkg::GPU_HIGH_R);
  assign lo_x_cpu = 31'(target_c) * 31'(ftdg_pkg::CPU_LOW_R);
  assign hi_x_cpu = 31'(target_c) * 31'(ftdg_pkg::CPU_HIGH_R);
  // Reported band edges, divided by 1000 through a reciprocal
  assign lo_q_gpu = 51'(target_c) * 51'(ftdg_pkg::GPU_LOW_MUL);
  assign hi_q_gpu = 51'(target_c) * 51'(ftdg_pkg::GPU_HIGH_MUL);
  assign lo_q_cpu = 51'(target_c) * 51'(ftdg_pkg::CPU_LOW_MUL);
  assign hi_q_cpu = 51'(target_c) * 51'(ftdg_pkg::CPU_HIGH_MUL);

  assign lo_x = gpu_ok ? lo_x_gpu : lo_x_cpu;
  assign hi_x = gpu_ok ? hi_x_gpu : hi_x_cpu;

  assign fx    = 34'(frame) * 34'd1000;
  assign over  = fx > 34'(hi_x);
  assign under = fx < 34'(lo_x);

  assign ov_acc = over  ? sat_add(st_i.overload, dt_c) : 25'd0;
  assign hr_acc = under ? sat_add(st_i.headroom, dt_c) : 25'd0;

  assign mn  = cfg_i.min_dist;
  assign mx  = ftdg_pkg::lim_max(cfg_i);
  assign cur = st_i.distance;

  assign dec_next = ((cur - mn) > cfg_i.dec_step) ? cur - cfg_i.dec_step : mn;
  assign inc_sum  = {1'b0, cur} + {1'b0, cfg_i.inc_step};
  assign inc_next = (inc_sum > {1'b0, mx}) ? mx : inc_sum[15:0];

  always_comb begin
    st_o                    = st_i;
    res_o.changed           = 1'b0;
    res_o.decision          = ftdg_pkg::DCS_DISABLED;
    res_o.distance          = st_i.distance;
    res_o.used_gpu_time     = 1'b0;
    res_o.time_available    = 1'b0;
    res_o.chosen_frame_us   = 24'd0;
    res_o.low_threshold_us  = 21'd0;
    res_o.high_threshold_us = 21'd0;

    if (cfg_i.enable) begin
      st_o.cooldown  = cd_dec;
      st_o.headroom  = 25'd0;
      st_o.overload  = 25'd0;
      res_o.decision = ftdg_pkg::DCS_WAITING;
      if (item_i.rendering) begin
        res_o.used_gpu_time     = gpu_ok;
        res_o.time_available    = frame != 24'd0;
        res_o.chosen_frame_us   = frame;
        res_o.low_threshold_us  = gpu_ok ? lo_q_gpu[50:30] : lo_q_cpu[50:30];
        res_o.high_threshold_us = gpu_ok ? hi_q_gpu[50:30] : hi_q_cpu[50:30];
        if (frame != 24'd0) begin
          st_o.headroom  = hr_acc;
          st_o.overload  = ov_acc;
          res_o.decision = ftdg_pkg::DCS_HOLDING;
          if (cd_dec == 24'd0) begin
            if (ov_acc >= 25'(cfg_i.dec_delay) && cur > mn) begin
              st_o.distance = dec_next;
              st_o.overload = 25'd0;
              st_o.cooldown = cfg_i.cooldown;
              if (dec_next < cur) begin
                res_o.changed  = 1'b1;
                res_o.decision = ftdg_pkg::DCS_DECREASED;
              end
            end else if (hr_acc >= 25'(cfg_i.inc_delay) && cur < mx) begin
              st_o.distance = inc_next;
              st_o.headroom = 25'd0;
              st_o.cooldown = cfg_i.cooldown;
              if (inc_next > cur) begin
                res_o.changed  = 1'b1;
                res_o.decision = ftdg_pkg::DCS_INCREASED;
              end
            end
          end
        end
      end
      res_o.distance = st_o.distance;
    end
  end

endmodule

// ===== hdl/frame_time_distance_governor_top.sv =====
// Top level of the frame time distance governor: stream ports, input and
// result registers, governor state. Depends on ftdg_pkg, ftdg_cfg, ftdg_step.
//
//  Channel   Direction  Handshake                 Content
//  s_axis    in         tvalid/tready             one frame report per transfer
//  m_axis    out        tvalid/tready             one decision result per transfer
//  APB       in/out     psel/penable, pready=1    eight settings at 8*index
//
// One report per cycle sustained unless m_axis stalls; a result passes the input
// and result registers. The rate is set by the loop from the state registers
// through the step logic and back. A register write reloads the distance and clears
// the timers on the following cycle. Reset needs no clearing pass. A stalled m_axis
// holds its result and backs up into the input register, then into s_axis.
module frame_time_distance_governor_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [0] rendering, [1] gpu_valid, [25:2] gpu_frame_us, [49:26] cpu_frame_us,
  // [73:50] elapsed_us, [79:74] zero
  input  logic [79:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] changed, [3:1] decision, [19:4] distance, [20] used_gpu_time,
  // [21] time_available, [45:22] chosen_frame_us, [66:46] low_threshold_us,
  // [87:67] high_threshold_us
  output logic [87:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  ftdg_pkg::cfg_t    cfg;
  logic              reload;
  ftdg_pkg::item_t   s1_item_q;
  logic              s1_valid_q;
  logic              s1_adv;
  logic              s_xfer;
  ftdg_pkg::state_t  st_q;
  ftdg_pkg::state_t  st_d;
  ftdg_pkg::result_t res_d;
  ftdg_pkg::result_t res_q;
  logic              out_valid_q;

  ftdg_cfg u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .cfg_o    (cfg),
    .reload_o (reload)
  );

  ftdg_step u_step (
    .cfg_i  (cfg),
    .st_i   (st_q),
    .item_i (s1_item_q),
    .st_o   (st_d),
    .res_o  (res_d)
  );

  assign s1_adv        = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign s_xfer        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      s1_item_q.rendering    <= s_axis_tdata[0];
      s1_item_q.gpu_valid    <= s_axis_tdata[1];
      s1_item_q.gpu_frame_us <= s_axis_tdata[25:2];
      s1_item_q.cpu_frame_us <= s_axis_tdata[49:26];
      s1_item_q.elapsed_us   <= s_axis_tdata[73:50];
    end
    if (s1_adv) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      st_q        <= '{distance: ftdg_pkg::DIST_RESET, headroom: 25'd0,
                       overload: 25'd0, cooldown: 24'd0};
    end else begin
      if (s_xfer) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      // Reload wins; the user must keep the block idle whenever it fires, as nothing enforces it
      if (reload) begin
        st_q <= '{distance: ftdg_pkg::clamp_init(cfg), headroom: 25'd0,
                  overload: 25'd0, cooldown: 24'd0};
      end else if (s1_adv) begin
        st_q <= st_d;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {res_q.high_threshold_us, res_q.low_threshold_us,
                          res_q.chosen_frame_us, res_q.time_available,
                          res_q.used_gpu_time, res_q.distance,
                          res_q.decision, res_q.changed};

  // A moved distance always carries a step decision
  a_changed_has_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res_q.changed) |->
      (res_q.decision == ftdg_pkg::DCS_INCREASED ||
       res_q.decision == ftdg_pkg::DCS_DECREASED))
    else $error("changed result without increase or decrease decision");

  // Overload and headroom are never accumulated at the same time
  a_timers_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(st_q.headroom != 25'd0 && st_q.overload != 25'd0))
    else $error("headroom and overload both nonzero");

  // A register write leaves all timers cleared
  a_reload_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    reload |=> (st_q.headroom == 25'd0 && st_q.overload == 25'd0 &&
                st_q.cooldown == 24'd0))
    else $error("timers not cleared after register write");

endmodule

// ===== verif/tb_top.sv =====
// Self-checking bench for frame_time_distance_governor_top: drives frame reports on s_axis
// and register writes on APB, predicts each decision and compares it on m_axis.
// Depends on ftdg_pkg and the governor RTL only.
module tb_top;

  localparam int unsigned TIMER_SAT = 33554431;
  localparam int unsigned FRAME_TOP = 9999999;
  localparam int unsigned DT_TOP    = 1000000;
  localparam int          LONG_HOLD = 80;
  localparam int          DRAIN_CYCLES = 8;
  localparam int          SETTLE_LIMIT = 5000;

  // Settings copy, governor state and the queue of decisions still to arrive
  class distance_ledger;
    bit        en;
    bit [19:0] target;
    bit [15:0] min_d, max_d, init_d, inc_step, dec_step;
    bit [23:0] inc_delay, dec_delay, cool_set;
    bit [15:0] cur_dist;
    bit [24:0] headroom, overload;
    bit [23:0] cool_left;
    ftdg_pkg::result_t pending_decisions[$];
    int        n_errors, n_checked, n_up, n_down, n_off;

    function new();
      en        = ftdg_pkg::RST_ENABLE;
      target    = ftdg_pkg::RST_TARGET;
      min_d     = ftdg_pkg::RST_MIN;
      max_d     = ftdg_pkg::RST_MAX;
      init_d    = ftdg_pkg::RST_INIT;
      inc_step  = ftdg_pkg::RST_STEPS[15:0];
      dec_step  = ftdg_pkg::RST_STEPS[31:16];
      inc_delay = ftdg_pkg::RST_DELAYS[23:0];
      dec_delay = ftdg_pkg::RST_DELAYS[47:24];
      cool_set  = ftdg_pkg::RST_COOLDOWN;
      reload();
    endfunction

    function bit [15:0] upper();
      return (max_d < min_d) ? min_d : max_d;
    endfunction

    function void reload();
      cur_dist = init_d;
      if (cur_dist < min_d) cur_dist = min_d;
      if (cur_dist > upper()) cur_dist = upper();
      headroom  = '0;
      overload  = '0;
      cool_left = '0;
    endfunction

    function void write_reg(ftdg_pkg::reg_idx_e idx, bit [63:0] v);
      case (idx)
        ftdg_pkg::REG_ENABLE:   en = v[0];
        ftdg_pkg::REG_TARGET:   target = v[19:0];
        ftdg_pkg::REG_MIN:      min_d = v[15:0];
        ftdg_pkg::REG_MAX:      max_d = v[15:0];
        ftdg_pkg::REG_INIT:     init_d = v[15:0];
        ftdg_pkg::REG_STEPS: begin
          inc_step = v[15:0];
          dec_step = v[31:16];
        end
        ftdg_pkg::REG_DELAYS: begin
          inc_delay = v[23:0];
          dec_delay = v[47:24];
        end
        ftdg_pkg::REG_COOLDOWN: cool_set = v[23:0];
        default: ;
      endcase
      reload();
    endfunction

    function bit [24:0] sat_add(bit [24:0] a, bit [23:0] b);
      bit [25:0] s;
      s = {1'b0, a} + 26'(b);
      return (s > TIMER_SAT) ? 25'(TIMER_SAT) : s[24:0];
    endfunction

    // Advance the governor by one accepted report and queue the decision it yields
    function void note_report(ftdg_pkg::item_t it);
      ftdg_pkg::result_t r;
      bit [23:0]        dt, gpu, cpu, frame;
      bit               use_gpu;
      longint unsigned  tgt, low_x, high_x, fx;
      int               lo, hi;
      bit [15:0]        nxt;
      bit [16:0]        up;
      r = '0;
      r.decision = ftdg_pkg::DCS_DISABLED;
      r.distance = cur_dist;
      if (!en) begin
        n_off++;
        pending_decisions.push_back(r);
        return;
      end
      dt = (it.elapsed_us > DT_TOP) ? 24'(DT_TOP) : it.elapsed_us;
      cool_left = (cool_left > dt) ? cool_left - dt : '0;
      if (!it.rendering) begin
        headroom = '0;
        overload = '0;
        r.decision = ftdg_pkg::DCS_WAITING;
        pending_decisions.push_back(r);
        return;
      end
      gpu = (it.gpu_valid && it.gpu_frame_us != 0 && it.gpu_frame_us <= FRAME_TOP) ?
            it.gpu_frame_us : '0;
      cpu = (it.cpu_frame_us != 0 && it.cpu_frame_us <= FRAME_TOP) ? it.cpu_frame_us : '0;
      use_gpu = (gpu != 0);
      frame = use_gpu ? gpu : cpu;
      tgt = (target == 0) ? 1 : ((target > DT_TOP) ? DT_TOP : target);
      if (use_gpu) begin
        lo = ftdg_pkg::LOW_RATIO_PERMILLE;
        if (lo < 50) lo = 50;
        if (lo > 950) lo = 950;
        hi = ftdg_pkg::HIGH_RATIO_PERMILLE;
        if (hi < lo + 10) hi = lo + 10;
        if (hi > 1500) hi = 1500;
      end else begin
        lo = 850;
        hi = 1050;
      end
      low_x  = tgt * longint'(lo);
      high_x = tgt * longint'(hi);
      r.used_gpu_time     = use_gpu;
      r.time_available    = (frame != 0);
      r.chosen_frame_us   = frame;
      r.low_threshold_us  = 21'(low_x / 1000);
      r.high_threshold_us = 21'(high_x / 1000);
      if (frame == 0) begin
        headroom = '0;
        overload = '0;
        r.decision = ftdg_pkg::DCS_WAITING;
        pending_decisions.push_back(r);
        return;
      end
      fx = longint'(frame) * 1000;
      if (fx > high_x) begin
        overload = sat_add(overload, dt);
        headroom = '0;
      end else if (fx < low_x) begin
        headroom = sat_add(headroom, dt);
        overload = '0;
      end else begin
        headroom = '0;
        overload = '0;
      end
      r.decision = ftdg_pkg::DCS_HOLDING;
      if (cool_left == 0) begin
        if (overload >= dec_delay && cur_dist > min_d) begin
          nxt = (cur_dist - min_d > dec_step) ? cur_dist - dec_step : min_d;
          if (nxt < cur_dist) begin
            r.changed  = 1'b1;
            r.decision = ftdg_pkg::DCS_DECREASED;
            n_down++;
          end
          cur_dist  = nxt;
          overload  = '0;
          cool_left = cool_set;
        end else if (headroom >= inc_delay && cur_dist < upper()) begin
          up = cur_dist + inc_step;
          if (up > upper()) up = upper();
          if (up[15:0] > cur_dist) begin
            r.changed  = 1'b1;
            r.decision = ftdg_pkg::DCS_INCREASED;
            n_up++;
          end
          cur_dist  = up[15:0];
          headroom  = '0;
          cool_left = cool_set;
        end
      end
      r.distance = cur_dist;
      pending_decisions.push_back(r);
    endfunction

    function void cmp(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        n_errors++;
      end
    endfunction

    function void check_decision(ftdg_pkg::result_t got);
      ftdg_pkg::result_t want;
      if (pending_decisions.size() == 0) begin
        $error("distance: expected no result, got %0d", got.distance);
        n_errors++;
        return;
      end
      want = pending_decisions.pop_front();
      n_checked++;
      cmp("changed", want.changed, got.changed);
      cmp("decision", want.decision, got.decision);
      cmp("distance", want.distance, got.distance);
      cmp("used_gpu_time", want.used_gpu_time, got.used_gpu_time);
      cmp("time_available", want.time_available, got.time_available);
      cmp("chosen_frame_us", want.chosen_frame_us, got.chosen_frame_us);
      cmp("low_threshold_us", want.low_threshold_us, got.low_threshold_us);
      cmp("high_threshold_us", want.high_threshold_us, got.high_threshold_us);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // [0] rendering, [1] gpu_valid, [25:2] gpu_frame_us, [49:26] cpu_frame_us,
  // [73:50] elapsed_us, [79:74] zero
  logic [79:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // [0] changed, [3:1] decision, [19:4] distance, [20] used_gpu_time,
  // [21] time_available, [45:22] chosen_frame_us, [66:46] low_threshold_us,
  // [87:67] high_threshold_us
  logic [87:0] m_axis_tdata;
  logic        psel, penable, pwrite;
  logic [5:0]  paddr;
  logic [63:0] pwdata, prdata;
  logic        pready;

  distance_ledger sb;
  bit idle_on  = 1'b1;
  bit hold_req = 1'b0;
  int n_settings;

  always #10 clk_i = ~clk_i;

  frame_time_distance_governor_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  function automatic ftdg_pkg::item_t mk(bit act, bit gv, bit [23:0] gpu,
                                         bit [23:0] cpu, bit [23:0] dt);
    ftdg_pkg::item_t it;
    it.rendering    = act;
    it.gpu_valid    = gv;
    it.gpu_frame_us = gpu;
    it.cpu_frame_us = cpu;
    it.elapsed_us   = dt;
    return it;
  endfunction

  // Frame times below, within and above the band of the current budget, at its edges, or invalid
  function automatic bit [23:0] pick_frame(longint unsigned t);
    int unsigned r;
    case ($urandom_range(0, 9))
      0, 1: return 24'((t * $urandom_range(50, 849)) / 1000);
      2:    return 24'((t * $urandom_range(800, 1050)) / 1000);
      3, 4: return 24'((t * $urandom_range(1051, 3000)) / 1000);
      5: begin
        case ($urandom_range(0, 3))
          0:       r = 800;
          1:       r = 850;
          2:       r = 1000;
          default: r = 1050;
        endcase
        return 24'((t * r) / 1000 + $urandom_range(0, 2) - 1);
      end
      6:    return $urandom_range(0, 1) ? 24'd0 : 24'($urandom_range(10000000, 24'hFFFFFF));
      7:    return 24'($urandom_range(0, 24'hFFFFFF));
      default: return 24'((t * $urandom_range(600, 1400)) / 1000);
    endcase
  endfunction

  function automatic ftdg_pkg::item_t rand_report();
    longint unsigned t;
    bit [23:0]       dt;
    t = (sb.target == 0) ? 1 : ((sb.target > DT_TOP) ? DT_TOP : sb.target);
    case ($urandom_range(0, 7))
      0:       dt = '0;
      1:       dt = 24'($urandom_range(0, 24'hFFFFFF));
      2:       dt = 24'($urandom_range(DT_TOP - 2, DT_TOP + 2));
      default: dt = 24'($urandom_range(1, 32'(2 * t + 1)));
    endcase
    return mk($urandom_range(0, 15) != 0, $urandom_range(0, 1), pick_frame(t),
              pick_frame(t), dt);
  endfunction

  task automatic send_report(input ftdg_pkg::item_t it, input int gap);
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {6'b0, it.elapsed_us, it.cpu_frame_us, it.gpu_frame_us,
                     it.gpu_valid, it.rendering};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_report(it);
  endtask

  task automatic run_items(input int n, input bit no_gaps);
    repeat (n) begin
      send_report(rand_report(),
                  (!no_gaps && idle_on && $urandom_range(0, 4) == 0) ?
                  $urandom_range(1, 5) : 0);
    end
  endtask

  // Wait for every queued decision, then let the pipeline drain
  task automatic settle();
    int waited;
    waited = 0;
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (sb.pending_decisions.size() != 0 && waited < SETTLE_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cfg(input ftdg_pkg::reg_idx_e idx, input logic [63:0] val);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 3'b000};
    pwdata  = val;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.write_reg(idx, val);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic program_cfg(input bit en, input bit [19:0] tgt, input bit [15:0] mn,
                             input bit [15:0] mx, input bit [15:0] init,
                             input bit [31:0] steps, input bit [47:0] delays,
                             input bit [23:0] cool);
    settle();
    write_cfg(ftdg_pkg::REG_TARGET, 64'(tgt));
    write_cfg(ftdg_pkg::REG_MIN, 64'(mn));
    write_cfg(ftdg_pkg::REG_MAX, 64'(mx));
    write_cfg(ftdg_pkg::REG_INIT, 64'(init));
    write_cfg(ftdg_pkg::REG_STEPS, 64'(steps));
    write_cfg(ftdg_pkg::REG_DELAYS, 64'(delays));
    write_cfg(ftdg_pkg::REG_COOLDOWN, 64'(cool));
    write_cfg(ftdg_pkg::REG_ENABLE, 64'(en));
    // reload lands in the cycle after the write
    repeat (2) @(posedge clk_i);
    n_settings++;
  endtask

  task automatic program_random();
    int unsigned t, mn, mx;
    t  = ($urandom_range(0, 3) == 0) ? $urandom_range(1000, 1000000) :
                                       $urandom_range(1000, 40000);
    mn = $urandom_range(0, 30000);
    mx = mn + $urandom_range(0, 35535);
    if ($urandom_range(0, 7) == 0) mx = $urandom_range(0, 65535);
    program_cfg(1'b1, 20'(t), 16'(mn), 16'(mx), 16'($urandom_range(0, 65535)),
                {16'($urandom_range(0, 600)), 16'($urandom_range(0, 600))},
                {24'($urandom_range(0, 6 * t)), 24'($urandom_range(0, 6 * t))},
                $urandom_range(0, 1) ? 24'd0 : 24'($urandom_range(0, 3 * t)));
  endtask

  // Result side: random stalls, one long hold on request
  task automatic take_result(input bit rdy);
    ftdg_pkg::result_t got;
    @(negedge clk_i);
    m_axis_tready = rdy;
    @(posedge clk_i);
    if (m_axis_tvalid && rdy) begin
      got.changed           = m_axis_tdata[0];
      got.decision          = ftdg_pkg::decision_e'(m_axis_tdata[3:1]);
      got.distance          = m_axis_tdata[19:4];
      got.used_gpu_time     = m_axis_tdata[20];
      got.time_available    = m_axis_tdata[21];
      got.chosen_frame_us   = m_axis_tdata[45:22];
      got.low_threshold_us  = m_axis_tdata[66:46];
      got.high_threshold_us = m_axis_tdata[87:67];
      sb.check_decision(got);
    end
  endtask

  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        repeat (LONG_HOLD) take_result(1'b0);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 5)) take_result(1'b0);
      end else begin
        take_result(1'b1);
      end
    end
  end

  initial begin
    ftdg_pkg::item_t directed[$];
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    sb            = new();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: band edges, invalid times, field extremes
    directed.push_back(mk(0, 1, 24'd5000, 24'd5000, 24'd16000));
    directed.push_back(mk(1, 0, 24'hFFFFFF, 24'd0, 24'd16000));
    directed.push_back(mk(1, 1, 24'd0, 24'd10000000, 24'd16000));
    directed.push_back(mk(1, 1, 24'd9999999, 24'd1, 24'd0));
    directed.push_back(mk(1, 1, 24'd1, 24'd9999999, 24'hFFFFFF));
    directed.push_back(mk(1, 0, 24'd1, 24'd17501, 24'd1000));
    directed.push_back(mk(1, 0, 24'd0, 24'd17500, 24'd1000));
    directed.push_back(mk(1, 1, 24'd13333, 24'd0, 24'd1000000));
    directed.push_back(mk(1, 1, 24'd16667, 24'd0, 24'd500));
    directed.push_back(mk(1, 1, 24'd16668, 24'd3, 24'd1000001));
    directed.push_back(mk(1, 0, 24'd5000, 24'd10000000, 24'd1));
    directed.push_back(mk(1, 1, 24'd10000000, 24'd14166, 24'd999999));
    directed.push_back(mk(1, 1, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));
    directed.push_back(mk(0, 0, 24'd0, 24'd0, 24'd0));
    directed.push_back(mk(1, 1, 24'hAAAAAA, 24'h555555, 24'h0F0F0F));
    directed.push_back(mk(1, 1, 24'h555555, 24'hAAAAAA, 24'hF0F0F0));
    directed.push_back(mk(1, 0, 24'd0, 24'd14167, 24'd20000));
    foreach (directed[i]) send_report(directed[i], idle_on ? $urandom_range(0, 2) : 0);

    // Extreme settings: full steps, disabled, zero step with max below min,
    // target zero with longest delays and cooldown, target above range
    program_cfg(1'b1, 20'd1000, 16'd100, 16'd2000, 16'd0, 32'hFFFF_FFFF, 48'd0, 24'd0);
    run_items(40, 1'b0);
    program_cfg(1'b0, 20'd16667, 16'd0, 16'hFFFF, 16'd1234, ftdg_pkg::RST_STEPS,
                48'd0, 24'd0);
    run_items(40, 1'b0);
    program_cfg(1'b1, 20'd1000000, 16'd5000, 16'd1000, 16'hFFFF, 32'd0,
                {24'd20000, 24'd30000}, 24'd0);
    run_items(40, 1'b0);
    program_cfg(1'b1, 20'd0, 16'd0, 16'hFFFF, 16'd30000, {16'd50, 16'd100},
                {24'hFFFFFF, 24'hFFFFFF}, 24'hFFFFFF);
    run_items(40, 1'b0);
    program_cfg(1'b1, 20'hFFFFF, 16'd0, 16'hFFFF, 16'd0, {16'd1, 16'hFFFF}, 48'd0,
                24'd1500000);
    run_items(40, 1'b0);

    for (int p = 0; p < 5; p++) begin
      program_random();
      if (p == 1) begin
        // back up the result side so the input stalls
        hold_req = 1'b1;
        run_items(30, 1'b1);
        run_items(40, 1'b0);
      end else begin
        run_items(70, 1'b0);
      end
    end

    idle_on = 1'b0;
    program_random();
    run_items(60, 1'b0);
    settle();

    if (sb.pending_decisions.size() != 0) begin
      $error("decision: expected %0d more results, got none", sb.pending_decisions.size());
      sb.n_errors++;
    end
    $display("Checked %0d frame reports under %0d register settings (disabled, cooldown,",
             sb.n_checked, n_settings);
    $display("zero step, target extremes); %0d steps up, %0d down, %0d while disabled.",
             sb.n_up, sb.n_down, sb.n_off);
    if (sb.n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
